@@ rtl/core/trl_pkg.sv @@
// Package for the throttle ramp limiter: field widths, fixed-point constants,
// microcode opcodes and the read-only control program of the sequencer.
// No dependencies; every other file of the block depends on it.
package trl_pkg;

	localparam int LEVEL_W   = 16;
	localparam int POWER_W   = 17;
	localparam int TIME_W    = 32;
	localparam int RAMP_MS_W = 16;

	// Configuration port.
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;
	localparam logic CFG_IDX_RAMP_MS = 1'b0;
	localparam logic [RAMP_MS_W-1:0] RAMP_MS_RESET = 16'd1000;

	// Ramp arithmetic.
	localparam int US_PER_MS_W = 10;
	localparam logic [US_PER_MS_W-1:0] US_PER_MS = 10'd1000;
	localparam int SCALE_W = RAMP_MS_W + US_PER_MS_W;   // full_ramp_ms * 1000
	localparam int DEN_W   = SCALE_W + POWER_W;         // ramp duration times 2^16
	localparam int REM_W   = TIME_W + 16;               // elapsed scaled by 2^16
	localparam logic [POWER_W-1:0] POWER_ONE = 17'h10000;
	localparam logic [LEVEL_W-1:0] LEVEL_FULL = 16'h8000;
	localparam int FRAC_STEPS = LEVEL_W - 1;
	localparam int CNT_W = 4;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_STEPS - 1);
	localparam int SUM_W = LEVEL_W + 2;

	// Sequencer.
	localparam int STEP_W = 3;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_LOAD = 3'd1,
		OP_MUL1 = 3'd2,
		OP_MUL2 = 3'd3,
		OP_TEST = 3'd4,
		OP_DIV  = 3'd5,
		OP_EMIT = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		C_NEXT         = 3'd0,
		C_GOTO         = 3'd1,
		C_WAIT_IN      = 3'd2,
		C_JUMP_INSTANT = 3'd3,
		C_JUMP_SAT     = 3'd4,
		C_LOOP         = 3'd5,
		C_WAIT_OUT     = 3'd6
	} cond_t;

	typedef struct packed {
		op_t               op;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} uword_t;

	localparam logic [STEP_W-1:0] S_LOAD = 3'd0;
	localparam logic [STEP_W-1:0] S_MUL1 = 3'd1;
	localparam logic [STEP_W-1:0] S_MUL2 = 3'd2;
	localparam logic [STEP_W-1:0] S_TEST = 3'd3;
	localparam logic [STEP_W-1:0] S_DIV  = 3'd4;
	localparam logic [STEP_W-1:0] S_EMIT = 3'd5;

	// The control program, one word per step.
	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		case (step)
			S_LOAD:  w = '{OP_LOAD, C_WAIT_IN,      S_LOAD};
			S_MUL1:  w = '{OP_MUL1, C_JUMP_INSTANT, S_EMIT};
			S_MUL2:  w = '{OP_MUL2, C_NEXT,         S_LOAD};
			S_TEST:  w = '{OP_TEST, C_JUMP_SAT,     S_EMIT};
			S_DIV:   w = '{OP_DIV,  C_LOOP,         S_DIV};
			S_EMIT:  w = '{OP_EMIT, C_WAIT_OUT,     S_LOAD};
			default: w = '{OP_NONE, C_GOTO,         S_LOAD};
		endcase
		return w;
	endfunction

endpackage

@@ rtl/core/trl_in_if.sv @@
// Input channel of the throttle ramp limiter: valid/ready handshake and the
// item fields. Depends on trl_pkg for the field widths.
interface trl_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [trl_pkg::LEVEL_W-1:0]   target_level;
	logic        [trl_pkg::POWER_W-1:0]   ramp_power;
	logic        [trl_pkg::TIME_W-1:0]    timestamp_us;

	modport source (output valid, output target_level, output ramp_power,
		output timestamp_us, input ready);
	modport sink (input valid, input target_level, input ramp_power,
		input timestamp_us, output ready);
endinterface

@@ rtl/core/trl_out_if.sv @@
// Output channel of the throttle ramp limiter: valid/ready handshake and the
// limited level. Depends on trl_pkg for the field width.
interface trl_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [trl_pkg::LEVEL_W-1:0] output_level;

	modport source (output valid, output output_level, input ready);
	modport sink (input valid, input output_level, output ready);
endinterface

@@ rtl/core/throttle_ramp_limiter.sv @@
// Throttle ramp limiter: microcoded sequencer with a restoring divider.
// Depends on trl_pkg, trl_in_if and trl_out_if.
//
// The block takes one item at a time: a signed Q1.15 target, a Q1.16 ramp
// power and a wrapping microsecond timestamp, and returns one limited level per
// item. A held level pointing the wrong way drops to zero, one larger in
// magnitude than the target snaps to it, and otherwise the level ramps toward
// the target by the elapsed time over full_ramp_ms*1000*(1-power) microseconds,
// clamped to the target. A power of one or more, or a ramp time of zero, jumps
// to the target. An item that ramps passes through the load step, two multiply
// steps that form the ramp duration, the saturation test, the fifteen-step
// quotient loop of the divider, one bit per cycle, and the step that registers
// the result. A step that saturates at full scale skips the loop, and a jump
// goes from the first multiply step straight to that last step. The next item
// is accepted only once the result is registered; a result that finds the
// output register still full waits in the last step for as long as the
// receiver holds off. The result waits in an output register. The user must
// write full_ramp_ms (byte address 0, reset 1000) over the APB port only while
// no item is in flight; the block itself does not enforce this.
module throttle_ramp_limiter (
	input  logic                              clk,
	input  logic                              arst_n,
	trl_in_if.sink                            cmd,
	trl_out_if.source                         res,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [trl_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [trl_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [trl_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                              pready
);
	import trl_pkg::*;

	// Sequencer and architectural state.
	logic [STEP_W-1:0]        step_q;
	logic                     out_valid_q;
	logic signed [LEVEL_W-1:0] level_q;
	logic [TIME_W-1:0]        last_time_q;
	logic [RAMP_MS_W-1:0]     ramp_ms_q;

	// Datapath registers; they carry no reset.
	logic signed [LEVEL_W-1:0] target_q;
	logic [POWER_W-1:0]       power_q;
	logic [TIME_W-1:0]        time_q;
	logic signed [LEVEL_W-1:0] cur_q;
	logic [TIME_W-1:0]        elapsed_q;
	logic [SCALE_W-1:0]       scale_q;
	logic [DEN_W-1:0]         den_q;
	logic [REM_W-1:0]         rem_q;
	logic [LEVEL_W-1:0]       inc_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [LEVEL_W-1:0] out_level_q;

	uword_t                   uw;
	logic                     pos;
	logic                     instant;
	logic                     sat;
	logic                     out_free;
	logic signed [LEVEL_W-1:0] cur_adj;
	logic [POWER_W-1:0]       power_comp;
	logic [REM_W-1:0]         rem_shift;
	logic                     div_ge;
	logic signed [SUM_W-1:0]  sum;
	logic signed [LEVEL_W-1:0] next_level;
	logic [STEP_W-1:0]        step_inc;
	logic [STEP_W-1:0]        step_nxt;
	logic                     cfg_wr;

	assign uw       = ucode(step_q);
	assign step_inc = step_q + 1'b1;
	assign out_free = !out_valid_q || res.ready;

	// Items enter only while the program waits at its first step.
	assign cmd.ready = (step_q == S_LOAD);
	assign res.valid = out_valid_q;
	assign res.output_level = out_level_q;

	// A full power or a zero ramp time skips the ramp and lands on the target.
	assign pos     = !target_q[LEVEL_W-1];
	assign instant = (power_q >= POWER_ONE) || (ramp_ms_q == '0);
	assign sat     = rem_q >= REM_W'(den_q);
	assign power_comp = POWER_ONE - power_q;

	// Direction and magnitude rules applied to the held level.
	always_comb begin
		if (pos && level_q < 0) begin
			cur_adj = '0;
		end else if (!pos && level_q > 0) begin
			cur_adj = '0;
		end else if (pos && target_q < level_q) begin
			cur_adj = target_q;
		end else if (!pos && target_q > level_q) begin
			cur_adj = target_q;
		end else begin
			cur_adj = level_q;
		end
	end

	// One restoring division step: a quotient bit per cycle.
	assign rem_shift = {rem_q[REM_W-2:0], 1'b0};
	assign div_ge    = rem_shift >= REM_W'(den_q);

	// Apply the increment in the target's direction, then clamp to the target.
	always_comb begin
		if (pos) begin
			sum = SUM_W'(cur_q) + SUM_W'({1'b0, inc_q});
		end else begin
			sum = SUM_W'(cur_q) - SUM_W'({1'b0, inc_q});
		end
		if (instant) begin
			next_level = target_q;
		end else if (pos && sum > SUM_W'(target_q)) begin
			next_level = target_q;
		end else if (!pos && sum < SUM_W'(target_q)) begin
			next_level = target_q;
		end else begin
			next_level = sum[LEVEL_W-1:0];
		end
	end

	// Branch unit of the sequencer.
	always_comb begin
		case (uw.cond)
			C_NEXT:         step_nxt = step_inc;
			C_GOTO:         step_nxt = uw.target;
			C_WAIT_IN:      step_nxt = cmd.valid ? step_inc : step_q;
			C_JUMP_INSTANT: step_nxt = instant ? uw.target : step_inc;
			C_JUMP_SAT:     step_nxt = sat ? uw.target : step_inc;
			C_LOOP:         step_nxt = (cnt_q != CNT_LAST) ? uw.target : step_inc;
			C_WAIT_OUT:     step_nxt = out_free ? uw.target : step_q;
			default:        step_nxt = S_LOAD;
		endcase
	end

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[CFG_ADDR_W-1] == CFG_IDX_RAMP_MS) ?
		CFG_DATA_W'(ramp_ms_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= S_LOAD;
			out_valid_q <= 1'b0;
			level_q     <= '0;
			last_time_q <= '0;
			ramp_ms_q   <= RAMP_MS_RESET;
		end else begin
			step_q <= step_nxt;
			if (cfg_wr && paddr[CFG_ADDR_W-1] == CFG_IDX_RAMP_MS) begin
				ramp_ms_q <= pwdata[RAMP_MS_W-1:0];
			end
			if (uw.op == OP_EMIT && out_free) begin
				out_valid_q <= 1'b1;
				level_q     <= next_level;
				last_time_q <= time_q;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath: the opcode of the current control word selects what loads.
	always_ff @(posedge clk) begin
		case (uw.op)
			OP_LOAD: begin
				if (cmd.valid) begin
					target_q <= cmd.target_level;
					power_q  <= cmd.ramp_power;
					time_q   <= cmd.timestamp_us;
				end
			end
			OP_MUL1: begin
				cur_q     <= cur_adj;
				elapsed_q <= time_q - last_time_q;
				scale_q   <= SCALE_W'(ramp_ms_q) * SCALE_W'(US_PER_MS);
			end
			OP_MUL2: begin
				den_q <= DEN_W'(scale_q) * DEN_W'(power_comp);
				rem_q <= {elapsed_q, 16'h0000};
			end
			OP_TEST: begin
				inc_q <= sat ? LEVEL_FULL : '0;
				cnt_q <= '0;
			end
			OP_DIV: begin
				rem_q <= div_ge ? (rem_shift - REM_W'(den_q)) : rem_shift;
				inc_q <= {inc_q[LEVEL_W-2:0], div_ge};
				cnt_q <= cnt_q + 1'b1;
			end
			OP_EMIT: begin
				if (out_free) begin
					out_level_q <= next_level;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
